>>> hdl/periodic_priority_task_scheduler_defines.svh
// assertion macros for the task scheduler
`ifndef PERIODIC_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PPTS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define PPTS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> hdl/ppts_pkg.sv
// shared types and codes for the task scheduler
package ppts_pkg;
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_DISP   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NULL   = 3'd1,
    ST_PERIOD = 3'd2,
    ST_PRIO   = 3'd3,
    ST_FULL   = 3'd4,
    ST_EMPTY  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRD,
    S_WCHK,
    S_DSCAN,
    S_DRD,
    S_DPUSH,
    S_DONE
  } state_t;
endpackage

>>> hdl/ppts_ram.sv
// generic single-port-write ram with registered read
module ppts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/periodic_priority_task_scheduler.sv
// task scheduler: create, raw tick with wait-list walk, and priority dispatch
// sequence: create and a raw tick without system tick go straight to the result;
//   dispatch scans the ready queues from level 1 upward, reads the head entry and
//   puts it back on the wait list if there is room; a system tick walks the wait
//   list one entry at a time, read then check, set by the single wait-list ram read port
// one item at a time; busy is high from acceptance until the result strobe
// rst is synchronous active high; it clears counts and queue pointers, not the rams
module periodic_priority_task_scheduler
  import ppts_pkg::*;
#(
  parameter int MAX_TASKS  = 8,
  parameter int PRIORITIES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  task_id,
  input  logic [15:0] period,
  input  logic [2:0]  priority_req,
  input  logic [15:0] initial_delay,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        dispatched,
  output logic [7:0]  run_task_id,
  output logic        system_tick
);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int QW = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int RW = $clog2(PRIORITIES * MAX_TASKS);
  localparam int WEW = 8 + 16 + 3 + 16;
  localparam int REW = 8 + 16;

  state_t state, state_next;

  logic [7:0]  tick_divide;
  logic [7:0]  raw_tick_count;
  logic [CW-1:0] wait_count;
  logic [IW-1:0] ready_head [PRIORITIES];
  logic [IW-1:0] ready_tail [PRIORITIES];
  logic [CW-1:0] ready_fill [PRIORITIES];

  logic [CW-1:0] idx;
  logic [IW-1:0] src;
  logic [QW-1:0] qsel;
  logic          moved;

  // wait-list ram
  logic           w_we;
  logic [IW-1:0]  w_waddr, w_raddr;
  logic [WEW-1:0] w_wdata, w_rdata;
  // ready ram
  logic           r_we;
  logic [RW-1:0]  r_waddr, r_raddr;
  logic [REW-1:0] r_wdata, r_rdata;

  ppts_ram #(.WIDTH(WEW), .DEPTH(MAX_TASKS)) u_wait (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  ppts_ram #(.WIDTH(REW), .DEPTH(PRIORITIES * MAX_TASKS)) u_ready (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  logic [7:0]  e_task;
  logic [15:0] e_per;
  logic [2:0]  e_lvl;
  logic [15:0] e_rem, e_rem_dec;
  assign {e_task, e_per, e_lvl, e_rem} = w_rdata;
  assign e_rem_dec = (e_rem != 16'd0) ? e_rem - 16'd1 : 16'd0;
  logic [QW-1:0] e_q;
  assign e_q = QW'(e_lvl - 3'd1);
  logic e_push_ok;
  assign e_push_ok = (e_rem_dec == 16'd0) && (ready_fill[e_q] < CW'(MAX_TASKS));

  // latched item
  logic [1:0]  op_r;
  logic [7:0]  id_r;
  logic [15:0] per_r, dly_r;
  logic [2:0]  pri_r;

  logic [7:0] raw_inc;
  assign raw_inc = raw_tick_count + 8'd1;

  logic [QW-1:0] cq;
  assign cq = QW'(pri_r - 3'd1);
  logic pri_bad;
  assign pri_bad = (pri_r == 3'd0) || (pri_r > 3'(PRIORITIES));

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    w_raddr = src;
    r_raddr = RW'(qsel) * RW'(MAX_TASKS) + RW'(ready_head[qsel]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode_t'(opcode))
            OP_CREATE: state_next = S_DONE;
            OP_TICK: state_next = (raw_inc == tick_divide && wait_count != '0) ?
                                  S_WRD : S_DONE;
            OP_DISP: state_next = S_DSCAN;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WRD:  state_next = S_WCHK;
      S_WCHK: begin
        if (moved) begin
          state_next = (idx < wait_count - CW'(1) + CW'(0) && idx + CW'(1) <= wait_count - CW'(1))
                       ? S_WRD : ((idx < wait_count - CW'(1)) ? S_WRD : S_DONE);
        end else begin
          state_next = (idx + CW'(1) < wait_count) ? S_WRD : S_DONE;
        end
      end
      S_DSCAN: begin
        if (ready_fill[qsel] != '0) state_next = S_DRD;
        else if (qsel == QW'(PRIORITIES - 1)) state_next = S_DONE;
      end
      S_DRD:   state_next = S_DPUSH;
      S_DPUSH: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // moved: the last entry is read next and handled as the entry at the same index,
  // so a kept entry is always written back at idx
  always_comb begin
    moved = (state == S_WCHK) && e_push_ok;
    w_we = 1'b0;
    w_waddr = idx[IW-1:0];
    w_wdata = {e_task, e_per, e_lvl, e_rem_dec};
    r_we = 1'b0;
    r_waddr = RW'(e_q) * RW'(MAX_TASKS) + RW'(ready_tail[e_q]);
    r_wdata = {e_task, e_per};
    unique case (state)
      S_WCHK: begin
        if (e_push_ok) begin
          r_we = 1'b1;
        end else begin
          w_we = 1'b1;
        end
      end
      S_DPUSH: begin
        w_waddr = wait_count[IW-1:0];
        w_wdata = {r_rdata[23:16], r_rdata[15:0], 3'(qsel) + 3'd1,
                   (r_rdata[15:0] != 16'd0) ? r_rdata[15:0] - 16'd1 : 16'd0};
        w_we = (wait_count < CW'(MAX_TASKS));
      end
      S_DONE: begin
        if (op_r == OP_CREATE && id_r != 8'd0 && per_r != 16'd0 && !pri_bad) begin
          if (dly_r != 16'd0) begin
            w_waddr = wait_count[IW-1:0];
            w_wdata = {id_r, per_r, pri_r, dly_r};
            w_we = (wait_count < CW'(MAX_TASKS));
          end else begin
            r_waddr = RW'(cq) * RW'(MAX_TASKS) + RW'(ready_tail[cq]);
            r_wdata = {id_r, per_r};
            r_we = (ready_fill[cq] < CW'(MAX_TASKS));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick_divide <= 8'd1;
      raw_tick_count <= '0;
      wait_count <= '0;
      idx <= '0;
      src <= '0;
      qsel <= '0;
      done <= 1'b0;
      for (int p = 0; p < PRIORITIES; p++) begin
        ready_head[p] <= '0;
        ready_tail[p] <= '0;
        ready_fill[p] <= '0;
      end
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_valid && cfg_ready) tick_divide <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r <= opcode; id_r <= task_id; per_r <= period;
            pri_r <= priority_req; dly_r <= initial_delay;
            idx <= '0; src <= '0; qsel <= '0;
            status <= ST_OK; dispatched <= 1'b0; run_task_id <= '0;
            system_tick <= 1'b0;
            if (opcode_t'(opcode) == OP_TICK) begin
              if (raw_inc == tick_divide) begin
                raw_tick_count <= '0;
                system_tick <= 1'b1;
              end else begin
                raw_tick_count <= raw_inc;
              end
            end
          end
        end
        S_WRD: ;
        S_WCHK: begin
          if (e_push_ok) begin
            ready_tail[e_q] <= (ready_tail[e_q] == IW'(MAX_TASKS - 1)) ? '0 : ready_tail[e_q] + IW'(1);
            ready_fill[e_q] <= ready_fill[e_q] + CW'(1);
            wait_count <= wait_count - CW'(1);
            src <= IW'(wait_count - CW'(1));
          end else begin
            idx <= idx + CW'(1);
            src <= IW'(idx + CW'(1));
          end
        end
        S_DSCAN: begin
          if (ready_fill[qsel] == '0) begin
            if (qsel == QW'(PRIORITIES - 1)) status <= ST_EMPTY;
            else qsel <= qsel + QW'(1);
          end
        end
        S_DPUSH: begin
          ready_head[qsel] <= (ready_head[qsel] == IW'(MAX_TASKS - 1)) ? '0 : ready_head[qsel] + IW'(1);
          ready_fill[qsel] <= ready_fill[qsel] - CW'(1);
          dispatched <= 1'b1;
          run_task_id <= r_rdata[23:16];
          if (wait_count < CW'(MAX_TASKS)) wait_count <= wait_count + CW'(1);
          else status <= ST_FULL;
        end
        S_DONE: begin
          done <= 1'b1;
          if (op_r == OP_CREATE) begin
            if (id_r == 8'd0) status <= ST_NULL;
            else if (per_r == 16'd0) status <= ST_PERIOD;
            else if (pri_bad) status <= ST_PRIO;
            else if (dly_r != 16'd0) begin
              if (wait_count < CW'(MAX_TASKS)) wait_count <= wait_count + CW'(1);
              else status <= ST_FULL;
            end else begin
              if (ready_fill[cq] < CW'(MAX_TASKS)) begin
                ready_tail[cq] <= (ready_tail[cq] == IW'(MAX_TASKS - 1)) ? '0 : ready_tail[cq] + IW'(1);
                ready_fill[cq] <= ready_fill[cq] + CW'(1);
              end else status <= ST_FULL;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `include "periodic_priority_task_scheduler_defines.svh"

  `PPTS_ASSERT_IMP(a_done_busy, clk, rst, done, !busy, "result strobe while busy")
  `PPTS_ASSERT_IMP(a_wait_cap, clk, rst, 1'b1, wait_count <= CW'(MAX_TASKS), "wait count overflow")
  `PPTS_ASSERT_IMP(a_disp_id, clk, rst, done && !dispatched, run_task_id == 8'd0, "id without dispatch")
endmodule
